// File: src/csus_pkg.sv
// Shared types and constants for the chip scale-up selector.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package csus_pkg;

   localparam int FreqW  = 8;
   localparam int TimeW  = 31;
   localparam int PowerW = 12;
   localparam int IntvW  = 8;
   localparam int PosW   = 3;

   localparam int ReqDataW  = 120;
   localparam int RspDataW  = 8;
   localparam int CsrAddrW  = 3;
   localparam int CsrDataW  = 32;

   localparam logic [0:0] REG_MAX_SUPPLY_POWER    = 1'b0;
   localparam logic [0:0] REG_MIN_CHANGE_INTERVAL = 1'b1;

   localparam logic [PowerW-1:0] MAX_SUPPLY_POWER_RESET    = 12'd4095;
   localparam logic [IntvW-1:0]  MIN_CHANGE_INTERVAL_RESET = 8'd10;

   typedef struct packed {
      logic              present;
      logic [FreqW-1:0]  freq_code;
      logic [FreqW-1:0]  thermal_limit;
      logic [TimeW-1:0]  change_time;
      logic              aggressive;
      logic [TimeW-1:0]  time_now;
      logic              force_req;
      logic [PowerW-1:0] supply_power;
      logic [PowerW-1:0] loop_current;
      logic [PowerW-1:0] loop_current_limit;
      logic              last;
   } rec_type;

   typedef struct packed {
      logic [PowerW-1:0] max_supply_power;
      logic [IntvW-1:0]  min_change_interval;
   } cfg_type;

   typedef struct packed {
      logic            found;
      logic [PosW-1:0] chosen_position;
   } result_type;

endpackage

`default_nettype wire

// File: src/chip_scale_up_selector_core.sv
// Chip scale-up selector: scans the chip records of one power loop and
// picks the chip to step up. A record is held in the input register; the fold is
// combinational, and the result of the last record is registered as it advances.
// Throughput: one record per cycle, except while a last record waits on a full output.
// Reset (synchronous) clears both stages and the scan state and loads register defaults.
// Depends on csus_pkg, csus_csr, csus_in_stage and csus_fold.
`timescale 1ns / 1ps
`default_nettype none

module chip_scale_up_selector_core #(
   parameter int CHIPS_PER_LOOP = 8
) (
   input  wire                              clock,
   input  wire                              reset,
   // present, freq_code, thermal_limit, change_time, aggressive, time_now,
   // force_req, supply_power, loop_current, loop_current_limit, zero pad
   input  wire  [csus_pkg::ReqDataW-1:0]    req_tdata,
   input  wire                              req_tlast,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // found, chosen_position, zero pad
   output logic [csus_pkg::RspDataW-1:0]    rsp_tdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [csus_pkg::CsrAddrW-1:0]    csr_paddr,
   input  wire  [csus_pkg::CsrDataW-1:0]    csr_pwdata,
   output logic [csus_pkg::CsrDataW-1:0]    csr_prdata,
   output logic                             csr_pready
);

   csus_pkg::cfg_type    cfg;
   csus_pkg::rec_type    rec_d, rec_q;
   csus_pkg::result_type result;
   logic                 s1_valid;
   logic                 out_free;
   logic                 advance;
   logic                 load;
   logic                 rsp_valid_ff, rsp_valid_in;
   csus_pkg::result_type rsp_ff, rsp_in;

   assign rec_d.present            = req_tdata[0];
   assign rec_d.freq_code          = req_tdata[8:1];
   assign rec_d.thermal_limit      = req_tdata[16:9];
   assign rec_d.change_time        = req_tdata[47:17];
   assign rec_d.aggressive         = req_tdata[48];
   assign rec_d.time_now           = req_tdata[79:49];
   assign rec_d.force_req          = req_tdata[80];
   assign rec_d.supply_power       = req_tdata[92:81];
   assign rec_d.loop_current       = req_tdata[104:93];
   assign rec_d.loop_current_limit = req_tdata[116:105];
   assign rec_d.last               = req_tlast;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid && (!rec_q.last || out_free);
   assign req_tready = !s1_valid || advance;
   assign load       = req_tvalid && req_tready;

   csus_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   csus_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .advance (advance),
      .rec_d   (rec_d),
      .valid   (s1_valid),
      .rec_q   (rec_q)
   );

   csus_fold #(
      .CHIPS_PER_LOOP (CHIPS_PER_LOOP)
   ) u_fold (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rec     (rec_q),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && rec_q.last) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.chosen_position, rsp_ff.found};

endmodule

`default_nettype wire

// File: src/csus_csr.sv
// Configuration registers of the chip scale-up selector, APB-style port.
// Depends on csus_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csus_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [csus_pkg::CsrAddrW-1:0]     csr_paddr,
   input  wire  [csus_pkg::CsrDataW-1:0]     csr_pwdata,
   output logic [csus_pkg::CsrDataW-1:0]     csr_prdata,
   output logic                              csr_pready,
   output csus_pkg::cfg_type                 cfg
);

   csus_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [0:0]        reg_idx;

   assign reg_idx    = csr_paddr[2:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            csus_pkg::REG_MAX_SUPPLY_POWER: begin
               cfg_in.max_supply_power = csr_pwdata[csus_pkg::PowerW-1:0];
            end
            csus_pkg::REG_MIN_CHANGE_INTERVAL: begin
               cfg_in.min_change_interval = csr_pwdata[csus_pkg::IntvW-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         csus_pkg::REG_MAX_SUPPLY_POWER: begin
            csr_prdata = {{(csus_pkg::CsrDataW-csus_pkg::PowerW){1'b0}},
                          cfg_ff.max_supply_power};
         end
         csus_pkg::REG_MIN_CHANGE_INTERVAL: begin
            csr_prdata = {{(csus_pkg::CsrDataW-csus_pkg::IntvW){1'b0}},
                          cfg_ff.min_change_interval};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_supply_power    <= csus_pkg::MAX_SUPPLY_POWER_RESET;
         cfg_ff.min_change_interval <= csus_pkg::MIN_CHANGE_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: src/csus_in_stage.sv
// Input register of the chip scale-up selector: holds one chip record.
// Depends on csus_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csus_in_stage (
   input  wire                clock,
   input  wire                reset,
   input  wire                load,
   input  wire                advance,
   input  csus_pkg::rec_type  rec_d,
   output logic               valid,
   output csus_pkg::rec_type  rec_q
);

   logic              valid_ff, valid_in;
   csus_pkg::rec_type rec_ff, rec_in;

   always_comb begin
      valid_in = valid_ff;
      rec_in   = rec_ff;
      if (load) begin
         valid_in = 1'b1;
         rec_in   = rec_d;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign valid = valid_ff;
   assign rec_q = rec_ff;

endmodule

`default_nettype wire

// File: src/csus_fold.sv
// Qualification check and best-chip fold of the chip scale-up selector.
// Keeps the scan state; depends on csus_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csus_fold #(
   parameter int CHIPS_PER_LOOP = 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  advance,
   input  csus_pkg::rec_type    rec,
   input  csus_pkg::cfg_type    cfg,
   output csus_pkg::result_type result
);

   // Positions are kept modulo 8, so a longer loop wraps the counter at 8.
   localparam int WrapLen = (CHIPS_PER_LOOP > (1 << csus_pkg::PosW)) ?
                            (1 << csus_pkg::PosW) : CHIPS_PER_LOOP;
   localparam logic [csus_pkg::PosW-1:0] PosLast = csus_pkg::PosW'(WrapLen - 1);

   logic [csus_pkg::PosW-1:0]  pos_ff, pos_in;
   logic                       best_valid_ff, best_valid_in;
   logic [csus_pkg::PosW-1:0]  best_position_ff, best_position_in;
   logic [csus_pkg::FreqW-1:0] best_freq_ff, best_freq_in;
   logic [csus_pkg::TimeW-1:0] best_time_ff, best_time_in;
   logic                       best_aggressive_ff, best_aggressive_in;

   logic [csus_pkg::TimeW:0]       age;
   logic                           qualify;
   logic                           take;
   logic                           upd_valid;
   logic [csus_pkg::PosW-1:0]      upd_position;
   logic [csus_pkg::FreqW-1:0]     upd_freq;
   logic [csus_pkg::TimeW-1:0]     upd_time;
   logic                           upd_aggressive;

   assign age     = {1'b0, rec.time_now} - {1'b0, rec.change_time};

   always_comb begin
      qualify = rec.present;
      if (rec.freq_code >= rec.thermal_limit) begin
         qualify = 1'b0;
      end
      if (age[csus_pkg::TimeW] ||
          (age[csus_pkg::TimeW-1:0] <
           {{(csus_pkg::TimeW-csus_pkg::IntvW){1'b0}}, cfg.min_change_interval})) begin
         qualify = 1'b0;
      end
      if (!rec.force_req) begin
         if (rec.supply_power >= cfg.max_supply_power) begin
            qualify = 1'b0;
         end
         if (rec.loop_current > rec.loop_current_limit) begin
            qualify = 1'b0;
         end
      end
   end

   always_comb begin
      if (!best_valid_ff) begin
         take = 1'b1;
      end else if (best_aggressive_ff) begin
         take = 1'b0;
      end else if (rec.aggressive) begin
         take = 1'b1;
      end else if (rec.change_time != best_time_ff) begin
         take = rec.change_time < best_time_ff;
      end else begin
         take = rec.freq_code < best_freq_ff;
      end
   end

   always_comb begin
      upd_valid      = best_valid_ff;
      upd_position   = best_position_ff;
      upd_freq       = best_freq_ff;
      upd_time       = best_time_ff;
      upd_aggressive = best_aggressive_ff;
      if (qualify && take) begin
         upd_valid      = 1'b1;
         upd_position   = pos_ff;
         upd_freq       = rec.freq_code;
         upd_time       = rec.change_time;
         upd_aggressive = rec.aggressive;
      end
   end

   assign result.found           = upd_valid;
   assign result.chosen_position = upd_valid ? upd_position : '0;

   always_comb begin
      pos_in             = pos_ff;
      best_valid_in      = best_valid_ff;
      best_position_in   = best_position_ff;
      best_freq_in       = best_freq_ff;
      best_time_in       = best_time_ff;
      best_aggressive_in = best_aggressive_ff;
      if (advance) begin
         if (rec.last) begin
            pos_in             = '0;
            best_valid_in      = 1'b0;
            best_position_in   = '0;
            best_freq_in       = '0;
            best_time_in       = '0;
            best_aggressive_in = 1'b0;
         end else begin
            pos_in             = (pos_ff == PosLast) ? '0 : pos_ff + 1'b1;
            best_valid_in      = upd_valid;
            best_position_in   = upd_position;
            best_freq_in       = upd_freq;
            best_time_in       = upd_time;
            best_aggressive_in = upd_aggressive;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff             <= '0;
         best_valid_ff      <= 1'b0;
         best_position_ff   <= '0;
         best_freq_ff       <= '0;
         best_time_ff       <= '0;
         best_aggressive_ff <= 1'b0;
      end else begin
         pos_ff             <= pos_in;
         best_valid_ff      <= best_valid_in;
         best_position_ff   <= best_position_in;
         best_freq_ff       <= best_freq_in;
         best_time_ff       <= best_time_in;
         best_aggressive_ff <= best_aggressive_in;
      end
   end

endmodule

`default_nettype wire
